// ===== rtl/thermal_current_limiter_assert.svh =====
// Assertion macros used by the checker file tcl_checker.sv.
`ifndef THERMAL_CURRENT_LIMITER_ASSERT_SVH
`define THERMAL_CURRENT_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermal_current_limiter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermal_current_limiter: assertion failed");

`endif

// ===== rtl/tcl_pkg.sv =====
package tcl_pkg;

    localparam int INTEGRAL_FULL_SCALE = 2048;
    localparam int RECOVERY_TICKS      = 32;
    localparam int FIFO_DEPTH          = 2;
    localparam int FIFO_AW             = $clog2(FIFO_DEPTH);
    localparam int DIV_BITS            = 16;
    localparam int DIV_CW              = $clog2(DIV_BITS);

    typedef logic signed [7:0]  temp_t;
    typedef logic [13:0]        cur_t;
    typedef logic signed [11:0] tw_t;
    typedef logic signed [15:0] acc_t;
    typedef logic signed [16:0] quo_t;
    typedef logic signed [19:0] wide_t;
    typedef logic [10:0]        den_t;

    typedef enum logic [2:0] {
        REG_HOLD_TEMP     = 3'd0,
        REG_RELEASE_TEMP  = 3'd1,
        REG_SHUTDOWN_TEMP = 3'd2,
        REG_TURBO_OFF     = 3'd3,
        REG_HOLD_CURRENT  = 3'd4,
        REG_FOLD_CURRENT  = 3'd5,
        REG_MIN_CURRENT   = 3'd6,
        REG_INT_DIVISOR   = 3'd7
    } reg_idx_t;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MODE = 1'b1;

    localparam temp_t      RST_HOLD_TEMP     = 8'sd50;
    localparam temp_t      RST_RELEASE_TEMP  = 8'sd45;
    localparam temp_t      RST_SHUTDOWN_TEMP = 8'sd75;
    localparam temp_t      RST_TURBO_OFF     = 8'sd65;
    localparam cur_t       RST_HOLD_CURRENT  = 14'd1500;
    localparam cur_t       RST_FOLD_CURRENT  = 14'd1000;
    localparam cur_t       RST_MIN_CURRENT   = 14'd100;
    localparam logic [9:0] RST_INT_DIVISOR   = 10'd64;

    localparam tw_t   OFS_LEAVE    = 12'sd10;
    localparam tw_t   OFS_HOLD     = 12'sd5;
    localparam tw_t   OFS_FOLD     = 12'sd13;
    localparam tw_t   OFS_INTEG    = 12'sd18;
    localparam tw_t   OFS_RELEASE  = 12'sd5;
    localparam tw_t   ERR_PF       = 12'sd2;
    localparam tw_t   ERR_SCALE    = 12'sd3;
    localparam tw_t   ERR_SWITCH   = 12'sd4;
    localparam tw_t   ERR_TRIM     = 12'sd1;
    localparam logic [8:0] ERR_BIAS = 9'd2;
    localparam wide_t TURBO_CUR    = 20'sd2850;
    localparam wide_t TURBO_GAIN   = 20'sd20;
    localparam wide_t MARGIN       = 20'sd200;
    localparam wide_t FOLD_MIN     = wide_t'(RECOVERY_TICKS * 8);
    localparam wide_t FULL_SCALE   = wide_t'(INTEGRAL_FULL_SCALE);
    localparam logic [7:0] LOCK_SHORT = 8'd24;
    localparam logic [7:0] LOCK_LONG  = 8'd60;

    // Reciprocals of 1000 and 1300 scaled by 2^24; exact for any 14-bit current.
    localparam logic [14:0] RECIP_TURBO  = 15'd16778;
    localparam logic [14:0] RECIP_NORMAL = 15'd12906;

    typedef struct packed {
        temp_t      hold_temp;
        temp_t      release_temp;
        temp_t      shutdown_temp;
        temp_t      turbo_off_temp;
        cur_t       hold_current;
        cur_t       foldback_current;
        cur_t       min_current;
        logic [9:0] integral_divisor;
    } cfg_t;

    typedef struct packed {
        logic  func;
        temp_t temperature;
        logic  sensor_ok;
        logic  output_enabled;
        logic  pause_calc;
        logic  needs_step_down;
        logic  is_turbo_mode;
        cur_t  target_current;
        cur_t  actual_current;
        cur_t  last_current;
        logic  display_idle;
    } item_t;

    typedef struct packed {
        cur_t current_limit;
        logic force_leave_turbo;
        logic disable_turbo;
        logic overheat_fault;
        logic sensor_fault;
        logic step_down_shown;
        logic limiter_active;
    } res_t;

    function automatic tw_t tx(temp_t x);
        return {{4{x[7]}}, x};
    endfunction

    function automatic wide_t tw2w(tw_t x);
        return {{8{x[11]}}, x};
    endfunction

    function automatic wide_t aw(acc_t x);
        return {{4{x[15]}}, x};
    endfunction

    function automatic wide_t uw(cur_t x);
        return {6'd0, x};
    endfunction

    function automatic wide_t qw(quo_t x);
        return {{3{x[16]}}, x};
    endfunction

    function automatic logic hyst(logic cur, tw_t t, tw_t hi, tw_t lo);
        logic r;
        if (t > hi)
        begin
            r = 1'b1;
        end
        else if (t < lo)
        begin
            r = 1'b0;
        end
        else
        begin
            r = cur;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tcl_fifo.sv =====
module tcl_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcl_pkg::item_t din,
    output logic          full,
    input  logic          pop,
    output tcl_pkg::item_t dout,
    output logic          empty
);
    import tcl_pkg::*;

    item_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tcl_div.sv =====
module tcl_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tcl_pkg::acc_t num,
    input  tcl_pkg::den_t den,
    output logic          done,
    output tcl_pkg::quo_t quo
);
    import tcl_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic                neg_reg;
    logic [DIV_BITS-1:0] mag_reg;
    den_t                rem_reg;
    den_t                den_reg;
    logic [11:0]         rem_sh;
    logic [11:0]         rem_diff;
    logic                ge;

    assign rem_sh   = {rem_reg, mag_reg[DIV_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quo      = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[15];
            mag_reg <= num[15] ? (~num + 16'd1) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[DIV_BITS-2:0], ge};
            rem_reg <= ge ? rem_diff[10:0] : rem_sh[10:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/tcl_core.sv =====
module tcl_core (
    input  logic           clk,
    input  logic           rst_n,
    input  tcl_pkg::cfg_t  cfg,
    input  tcl_pkg::item_t item_in,
    input  logic           item_empty,
    output logic           item_pop,
    output tcl_pkg::res_t  res,
    output logic           res_empty,
    input  logic           res_pop
);
    import tcl_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_FLAGS     = 12'b000000000010,
        ST_LOOP      = 12'b000000000100,
        ST_PF_WAIT   = 12'b000000001000,
        ST_PF_MUL1   = 12'b000000010000,
        ST_PF_MUL2   = 12'b000000100000,
        ST_FOLD_WAIT = 12'b000001000000,
        ST_FIX       = 12'b000010000000,
        ST_INTEG     = 12'b000100000000,
        ST_LIM       = 12'b001000000000,
        ST_LIM_WAIT  = 12'b010000000000,
        ST_OUT       = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    item_t       item_reg, item_next;
    acc_t        ia_reg, ia_next;
    acc_t        pr_reg, pr_next;
    logic [7:0]  lock_reg, lock_next;
    logic        nf_reg, nf_next;
    logic        sd_reg, sd_next;
    logic        lo_reg, lo_next;
    logic        sh_reg, sh_next;
    logic        lt_reg, lt_next;
    logic        tb_reg, tb_next;
    logic        up_reg, up_next;
    logic        fast_reg, fast_next;
    logic [13:0] pf_reg, pf_next;
    cur_t        limit_reg, limit_next;
    res_t        res_reg;
    logic        res_valid_reg;
    logic        res_load;

    logic        div_start;
    acc_t        div_num;
    den_t        div_den;
    logic        div_done;
    quo_t        div_quo;

    tw_t         t, hold, rel, shut, toff;
    tw_t         err_hot, err_cold;
    logic [8:0]  errh_u;
    cur_t        cst;
    logic        act_lt_cst;
    logic        sw;
    wide_t       ia_w, ia_mag, quo_w;
    logic        fold_need;
    logic        lo_calc;
    wide_t       mode_p;
    tw_t         d_raw, d_pos;
    logic        fast_ok;
    wide_t       d_step, ia_int;
    wide_t       r_sum, r_pos, r_lim, r_fin, head;
    wide_t       pr_hot, pr_trim, pr_fold;
    logic [22:0] pf_prod;
    logic [13:0] pf_scaled;
    logic [28:0] pf_recip;
    den_t        divisor;

    tcl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign t        = tx(item_reg.temperature);
    assign hold     = tx(cfg.hold_temp);
    assign rel      = tx(cfg.release_temp);
    assign shut     = tx(cfg.shutdown_temp);
    assign toff     = tx(cfg.turbo_off_temp);
    assign err_hot  = t - hold;
    assign err_cold = hold - t;
    assign errh_u   = err_hot[8:0];
    assign divisor  = (cfg.integral_divisor == '0) ? 11'd1 : {1'b0, cfg.integral_divisor};

    assign cst        = nf_reg ? cfg.foldback_current : cfg.hold_current;
    assign act_lt_cst = item_reg.actual_current < cst;
    assign sw         = (err_cold > ERR_SWITCH)
                        || !(uw(item_reg.actual_current) > uw(cst) - MARGIN);

    assign ia_w      = aw(ia_reg);
    assign ia_mag    = ia_reg[15] ? -ia_w : ia_w;
    assign fold_need = ia_mag >= FOLD_MIN;
    assign quo_w     = qw(div_quo);

    assign lo_calc = !item_reg.needs_step_down ? 1'b0
                   : hyst(lo_reg, t, hold, rel) ? 1'b1
                   : ((pr_reg == '0) && ia_reg[15]) ? 1'b0 : lo_reg;
    assign mode_p  = uw(item_reg.target_current) - uw(item_reg.last_current);

    assign d_raw   = up_reg ? t - (shut - OFS_INTEG) : (rel + OFS_RELEASE) - t;
    assign d_pos   = d_raw[11] ? '0 : d_raw;
    assign fast_ok = fast_reg && (ia_mag < FULL_SCALE - tw2w(d_pos));
    assign d_step  = fast_ok ? (tw2w(d_pos) <<< 1) + 20'sd1 : 20'sd1;
    assign ia_int  = up_reg ? ia_w + d_step : ia_w - d_step;

    assign head    = uw(item_reg.target_current) - uw(cfg.min_current);
    assign r_sum   = aw(pr_reg) + quo_w;
    assign r_pos   = r_sum[19] ? '0 : r_sum;
    assign r_lim   = uw(item_reg.target_current) - r_pos;
    assign r_fin   = (r_lim < uw(cfg.min_current)) ? uw(cfg.min_current) : r_lim;

    assign pr_hot    = aw(pr_reg) + tw2w(err_hot) * TURBO_GAIN;
    assign pr_trim   = (err_cold > ERR_TRIM) ? aw(pr_reg) - tw2w(err_cold) : aw(pr_reg);
    assign pr_fold   = aw(pr_reg) + quo_w;
    assign pf_scaled = 14'(pf_reg[4:0] * (errh_u + ERR_BIAS));
    assign pf_prod   = 23'(pf_reg) * 23'(errh_u);
    assign pf_recip  = 29'(item_reg.actual_current)
                       * 29'(item_reg.is_turbo_mode ? RECIP_TURBO : RECIP_NORMAL);

    assign res_load  = (state_reg == ST_OUT) && (!res_valid_reg || res_pop);

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        ia_next    = ia_reg;
        pr_next    = pr_reg;
        lock_next  = lock_reg;
        nf_next    = nf_reg;
        sd_next    = sd_reg;
        lo_next    = lo_reg;
        sh_next    = sh_reg;
        lt_next    = lt_reg;
        tb_next    = tb_reg;
        up_next    = up_reg;
        fast_next  = fast_reg;
        pf_next    = pf_reg;
        limit_next = limit_reg;
        item_pop   = 1'b0;
        div_start  = 1'b0;
        div_num    = ia_reg;
        div_den    = divisor;
        case (state_reg)
            ST_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop   = 1'b1;
                    item_next  = item_in;
                    state_next = ST_FLAGS;
                end
            end
            ST_FLAGS:
            begin
                if (item_reg.func == FUNC_MODE)
                begin
                    if (!item_reg.needs_step_down || mode_p[19])
                    begin
                        pr_next = '0;
                    end
                    else
                    begin
                        pr_next = mode_p[15:0];
                    end
                    ia_next    = '0;
                    limit_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    if (item_reg.sensor_ok)
                    begin
                        lt_next = hyst(lt_reg, t, shut - OFS_LEAVE, toff - OFS_LEAVE);
                        tb_next = hyst(tb_reg, t, toff, toff - OFS_LEAVE);
                        sh_next = hyst(sh_reg, t, shut, hold - OFS_HOLD);
                        lo_next = lo_calc;
                    end
                    if (!(item_reg.sensor_ok ? lo_calc : lo_reg))
                    begin
                        nf_next    = 1'b0;
                        ia_next    = '0;
                        pr_next    = '0;
                        sd_next    = 1'b0;
                        state_next = ST_LIM;
                    end
                    else if (!item_reg.pause_calc && item_reg.output_enabled)
                    begin
                        state_next = ST_LOOP;
                    end
                    else
                    begin
                        state_next = ST_LIM;
                    end
                end
            end
            ST_LOOP:
            begin
                if (t > hold)
                begin
                    up_next   = 1'b1;
                    fast_next = act_lt_cst;
                    lock_next = LOCK_SHORT;
                    if (t > shut - OFS_FOLD)
                    begin
                        nf_next = 1'b1;
                    end
                    if (item_reg.is_turbo_mode && (uw(item_reg.actual_current) > TURBO_CUR))
                    begin
                        pr_next    = pr_hot[15:0];
                        state_next = ST_INTEG;
                    end
                    else if (err_hot > ERR_PF)
                    begin
                        lock_next = LOCK_LONG;
                        if (act_lt_cst)
                        begin
                            div_start  = fold_need;
                            state_next = fold_need ? ST_FOLD_WAIT : ST_FIX;
                        end
                        else
                        begin
                            state_next = ST_PF_WAIT;
                        end
                    end
                    else
                    begin
                        state_next = ST_INTEG;
                    end
                end
                else if (t < hold)
                begin
                    up_next    = 1'b0;
                    fast_next  = sw;
                    state_next = ST_FIX;
                    if (lock_reg != '0)
                    begin
                        lock_next = lock_reg - 8'd1;
                    end
                    else
                    begin
                        if (nf_reg && (item_reg.actual_current > cfg.hold_current))
                        begin
                            nf_next = 1'b0;
                        end
                        if (sw)
                        begin
                            div_start = fold_need;
                            if (fold_need)
                            begin
                                state_next = ST_FOLD_WAIT;
                            end
                        end
                        else
                        begin
                            pr_next = pr_trim[15:0];
                        end
                    end
                end
                else
                begin
                    state_next = ST_LIM;
                end
            end
            ST_PF_WAIT:
            begin
                pf_next    = 14'(pf_recip[28:24]) + 14'd1;
                state_next = ST_PF_MUL1;
            end
            ST_PF_MUL1:
            begin
                if (err_hot > ERR_SCALE)
                begin
                    pf_next = pf_scaled;
                end
                state_next = ST_PF_MUL2;
            end
            ST_PF_MUL2:
            begin
                pr_next    = pr_reg + pf_prod[15:0];
                state_next = ST_FIX;
            end
            ST_FOLD_WAIT:
            begin
                if (div_done)
                begin
                    pr_next    = pr_fold[15:0];
                    ia_next    = '0;
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (up_reg)
                begin
                    if (aw(pr_reg) > head)
                    begin
                        pr_next = head[15:0];
                    end
                end
                else if (pr_reg[15])
                begin
                    pr_next = '0;
                end
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                ia_next    = ia_int[15:0];
                state_next = ST_LIM;
            end
            ST_LIM:
            begin
                if (!lo_reg)
                begin
                    limit_next = item_reg.target_current;
                    sd_next    = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_LIM_WAIT;
                end
            end
            ST_LIM_WAIT:
            begin
                if (div_done)
                begin
                    if (r_lim < uw(cfg.min_current))
                    begin
                        pr_next = head[15:0];
                        ia_next = '0;
                    end
                    if (r_fin < uw(item_reg.target_current) - MARGIN)
                    begin
                        sd_next = 1'b1;
                    end
                    limit_next = r_fin[13:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        up_reg    <= up_next;
        fast_reg  <= fast_next;
        pf_reg    <= pf_next;
        limit_reg <= limit_next;
        if (res_load)
        begin
            res_reg.current_limit     <= limit_reg;
            res_reg.force_leave_turbo <= lt_reg;
            res_reg.disable_turbo     <= tb_reg;
            res_reg.overheat_fault    <= sh_reg;
            res_reg.sensor_fault      <= !item_reg.sensor_ok;
            res_reg.step_down_shown   <= sd_reg && item_reg.display_idle;
            res_reg.limiter_active    <= lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ia_reg        <= '0;
            pr_reg        <= '0;
            lock_reg      <= '0;
            nf_reg        <= 1'b0;
            sd_reg        <= 1'b0;
            lo_reg        <= 1'b0;
            sh_reg        <= 1'b0;
            lt_reg        <= 1'b0;
            tb_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ia_reg    <= ia_next;
            pr_reg    <= pr_next;
            lock_reg  <= lock_next;
            nf_reg    <= nf_next;
            sd_reg    <= sd_next;
            lo_reg    <= lo_next;
            sh_reg    <= sh_next;
            lt_reg    <= lt_next;
            tb_reg    <= tb_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res       = res_reg;
    assign res_empty = !res_valid_reg;

endmodule

// ===== rtl/thermal_current_limiter.sv =====
// Thermal current limiter. Items are pushed with push while full is low and land in a
// two-beat input queue; results are taken with pop while empty is low, the oldest first.
// Each item gives exactly one result beat.
// A tick beat updates the hysteresis flags when the sensor is ok, runs one step of the
// PI loop when the limiter is engaged and the loop is enabled and not paused, and
// computes the limit; a mode-change beat rebases the proportional term and clears the
// integral. Folding the integral and computing the limit use the shared bit-serial
// divider, which serves at most two divisions per tick; the pf_reg factor comes from a
// reciprocal multiply of the actual current. One item is processed at a time: the core
// takes the next item from the queue only once the result of the last one is loaded.
// The configuration registers are written through cfg_we, cfg_addr and cfg_wdata and
// take effect at once; they should only be written while the block is idle.
// Reset clears the loop state, the flags and both queues and loads the default
// thresholds and currents; no result is pending afterwards.
// A stalled receiver holds the result register; the core finishes the next item and
// waits with it, the input queue takes up to two more beats, and then full stays high
// until results are popped again.
module thermal_current_limiter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [13:0]        cfg_wdata,
    input  logic               func,
    input  tcl_pkg::temp_t     temperature,
    input  logic               sensor_ok,
    input  logic               output_enabled,
    input  logic               pause_calc,
    input  logic               needs_step_down,
    input  logic               is_turbo_mode,
    input  tcl_pkg::cur_t      target_current,
    input  tcl_pkg::cur_t      actual_current,
    input  tcl_pkg::cur_t      last_current,
    input  logic               display_idle,
    output tcl_pkg::cur_t      current_limit,
    output logic               force_leave_turbo,
    output logic               disable_turbo,
    output logic               overheat_fault,
    output logic               sensor_fault,
    output logic               step_down_shown,
    output logic               limiter_active
);
    import tcl_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    item_t q_item;
    logic  q_empty;
    logic  q_pop;
    res_t  res;

    assign in_item = '{
        func:            func,
        temperature:     temperature,
        sensor_ok:       sensor_ok,
        output_enabled:  output_enabled,
        pause_calc:      pause_calc,
        needs_step_down: needs_step_down,
        is_turbo_mode:   is_turbo_mode,
        target_current:  target_current,
        actual_current:  actual_current,
        last_current:    last_current,
        display_idle:    display_idle
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_temp        <= RST_HOLD_TEMP;
            cfg_reg.release_temp     <= RST_RELEASE_TEMP;
            cfg_reg.shutdown_temp    <= RST_SHUTDOWN_TEMP;
            cfg_reg.turbo_off_temp   <= RST_TURBO_OFF;
            cfg_reg.hold_current     <= RST_HOLD_CURRENT;
            cfg_reg.foldback_current <= RST_FOLD_CURRENT;
            cfg_reg.min_current      <= RST_MIN_CURRENT;
            cfg_reg.integral_divisor <= RST_INT_DIVISOR;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_HOLD_TEMP:     cfg_reg.hold_temp        <= cfg_wdata[7:0];
                REG_RELEASE_TEMP:  cfg_reg.release_temp     <= cfg_wdata[7:0];
                REG_SHUTDOWN_TEMP: cfg_reg.shutdown_temp    <= cfg_wdata[7:0];
                REG_TURBO_OFF:     cfg_reg.turbo_off_temp   <= cfg_wdata[7:0];
                REG_HOLD_CURRENT:  cfg_reg.hold_current     <= cfg_wdata;
                REG_FOLD_CURRENT:  cfg_reg.foldback_current <= cfg_wdata;
                REG_MIN_CURRENT:   cfg_reg.min_current      <= cfg_wdata;
                REG_INT_DIVISOR:   cfg_reg.integral_divisor <= cfg_wdata[9:0];
                default:           cfg_reg.hold_temp        <= cfg_reg.hold_temp;
            endcase
        end
    end

    tcl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    tcl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_in    (q_item),
        .item_empty (q_empty),
        .item_pop   (q_pop),
        .res        (res),
        .res_empty  (empty),
        .res_pop    (pop)
    );

    assign current_limit     = res.current_limit;
    assign force_leave_turbo = res.force_leave_turbo;
    assign disable_turbo     = res.disable_turbo;
    assign overheat_fault    = res.overheat_fault;
    assign sensor_fault      = res.sensor_fault;
    assign step_down_shown   = res.step_down_shown;
    assign limiter_active    = res.limiter_active;

endmodule

// ===== rtl/tcl_checker.sv =====
`include "thermal_current_limiter_assert.svh"

module tcl_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pop,
    input logic          empty,
    input tcl_pkg::cur_t current_limit,
    input logic          step_down_shown,
    input logic          limiter_active
);

    // A waiting result beat stays put until it is popped.
    `TCL_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(current_limit))

    // Step-down can only be shown while the limiter loop is engaged.
    `TCL_ASSERT_IMPL(a_step_down_engaged, !empty && step_down_shown, limiter_active)

    // No result beat is pending straight out of reset.
    `TCL_ASSERT_IMPL(a_reset_empty, $rose(rst_n), empty)

endmodule

bind thermal_current_limiter tcl_checker u_tcl_checker (.*);
